[hdl/pii_pkg.sv]
`default_nettype none

package pii_pkg;

	// default widths
	localparam int COORD_WIDTH_DEF = 32;
	localparam int IMAGE_WIDTH_DEF = 16;

	// snap tolerance register is fixed at 16 bits
	localparam int TOL_WIDTH = 16;

	// axes handled side by side
	localparam int NUM_AXES = 3;

	// configuration register map
	localparam int CFG_INDEX_WIDTH = 3;

	typedef enum logic [CFG_INDEX_WIDTH-1:0] {
		REG_X_LOW  = 3'd0,
		REG_X_HIGH = 3'd1,
		REG_Y_LOW  = 3'd2,
		REG_Y_HIGH = 3'd3,
		REG_Z_LOW  = 3'd4,
		REG_Z_HIGH = 3'd5,
		REG_TOL    = 3'd6
	} reg_idx_t;

	// reset values: box from 0.0 to 10.0 in Q16.16, tolerance of one LSB
	localparam int LOW_RESET  = 0;
	localparam int HIGH_RESET = 655360;
	localparam int TOL_RESET  = 1;

endpackage

`default_nettype wire

[hdl/pii_pos_if.sv]
`default_nettype none

interface pii_pos_if #(
	parameter int COORD_WIDTH = pii_pkg::COORD_WIDTH_DEF
);
	logic                          valid;
	logic                          ready;
	logic signed [COORD_WIDTH-1:0] pos_x;
	logic signed [COORD_WIDTH-1:0] pos_y;
	logic signed [COORD_WIDTH-1:0] pos_z;
	logic                          last_atom;

	modport source (output valid, pos_x, pos_y, pos_z, last_atom, input ready);
	modport sink   (input valid, pos_x, pos_y, pos_z, last_atom, output ready);
endinterface

`default_nettype wire

[hdl/pii_img_if.sv]
`default_nettype none

interface pii_img_if #(
	parameter int COORD_WIDTH = pii_pkg::COORD_WIDTH_DEF,
	parameter int IMAGE_WIDTH = pii_pkg::IMAGE_WIDTH_DEF
);
	logic                          valid;
	logic                          ready;
	logic signed [COORD_WIDTH-1:0] adj_x;
	logic signed [COORD_WIDTH-1:0] adj_y;
	logic signed [COORD_WIDTH-1:0] adj_z;
	logic signed [IMAGE_WIDTH-1:0] image_x;
	logic signed [IMAGE_WIDTH-1:0] image_y;
	logic signed [IMAGE_WIDTH-1:0] image_z;
	logic                          last_out;

	modport source (output valid, adj_x, adj_y, adj_z, image_x, image_y, image_z, last_out,
		input ready);
	modport sink   (input valid, adj_x, adj_y, adj_z, image_x, image_y, image_z, last_out,
		output ready);
endinterface

`default_nettype wire

[hdl/periodic_image_index_unit.sv]
// Stages in order: snap, box compare, one divider cell per image-count bit, and
// the output register. Throughput: one atom per cycle unless back-pressure
// stalls the output register; each divider cell resolves one quotient bit.
// Stages stall individually, so a held result does not block upstream until full.
// Reset (arst_n low) empties the pipeline and loads the box 0.0..10.0 on every
// axis with an edge tolerance of 1 LSB.
`default_nettype none

module periodic_image_index_unit #(
	parameter int COORD_WIDTH = pii_pkg::COORD_WIDTH_DEF,
	parameter int IMAGE_WIDTH = pii_pkg::IMAGE_WIDTH_DEF
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_we,
	input  wire logic [pii_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
	input  wire logic [COORD_WIDTH-1:0]              cfg_data,
	pii_pos_if.sink                                  pos,
	pii_img_if.source                                img
);
	import pii_pkg::*;

	localparam int CW = COORD_WIDTH;
	localparam int IW = IMAGE_WIDTH;

	localparam logic [IW-1:0] IMAX = {1'b0, {(IW-1){1'b1}}};
	localparam logic [IW-1:0] IMIN = {1'b1, {(IW-1){1'b0}}};

	// configuration registers
	logic signed [CW-1:0]  low_q [NUM_AXES];
	logic signed [CW-1:0]  high_q[NUM_AXES];
	logic [TOL_WIDTH-1:0]  tol_q;

	// chain links: index 0 is the front end output, j+1 is cell j output
	logic                 cv    [IW+1];
	logic                 cr    [IW+1];
	logic [CW-1:0]        crem  [IW+1][NUM_AXES];
	logic [CW-1:0]        clen  [IW+1][NUM_AXES];
	logic [IW-1:0]        cq    [IW+1][NUM_AXES];
	logic                 cneg  [IW+1][NUM_AXES];
	logic signed [CW-1:0] cadj  [IW+1][NUM_AXES];
	logic                 clast [IW+1];

	logic                 front_s1_valid;
	logic signed [CW-1:0] pos_vec [NUM_AXES];
	logic [IW-1:0]        img_next[NUM_AXES];

	logic                 out_valid_q;
	logic signed [CW-1:0] adj_q   [NUM_AXES];
	logic [IW-1:0]        img_q   [NUM_AXES];
	logic                 last_q;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int a = 0; a < NUM_AXES; a++) begin
				low_q[a]  <= CW'(LOW_RESET);
				high_q[a] <= CW'(HIGH_RESET);
			end
			tol_q <= TOL_WIDTH'(TOL_RESET);
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_X_LOW:  low_q[0]  <= cfg_data;
				REG_X_HIGH: high_q[0] <= cfg_data;
				REG_Y_LOW:  low_q[1]  <= cfg_data;
				REG_Y_HIGH: high_q[1] <= cfg_data;
				REG_Z_LOW:  low_q[2]  <= cfg_data;
				REG_Z_HIGH: high_q[2] <= cfg_data;
				REG_TOL:    tol_q     <= cfg_data[TOL_WIDTH-1:0];
				default: ;
			endcase
		end
	end

	assign pos_vec[0] = pos.pos_x;
	assign pos_vec[1] = pos.pos_y;
	assign pos_vec[2] = pos.pos_z;

	// snap and dividend setup
	pii_front #(
		.COORD_WIDTH(CW)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (pos.valid),
		.in_ready (pos.ready),
		.pos_in   (pos_vec),
		.last_in  (pos.last_atom),
		.low      (low_q),
		.high     (high_q),
		.tol      (tol_q),
		.out_valid(cv[0]),
		.out_ready(cr[0]),
		.rem_out  (crem[0]),
		.len_out  (clen[0]),
		.neg_out  (cneg[0]),
		.adj_out  (cadj[0]),
		.last_out (clast[0]),
		.s1_valid (front_s1_valid)
	);

	for (genvar a = 0; a < NUM_AXES; a++) begin : g_q0
		assign cq[0][a] = '0;
	end

	// divider chain; the first cell's bit flags a saturated count
	for (genvar j = 0; j < IW; j++) begin : g_cell
		pii_div_cell #(
			.COORD_WIDTH(CW),
			.IMAGE_WIDTH(IW),
			.SHIFT      (IW - 1 - j)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.in_valid (cv[j]),
			.in_ready (cr[j]),
			.rem_in   (crem[j]),
			.len_in   (clen[j]),
			.q_in     (cq[j]),
			.neg_in   (cneg[j]),
			.adj_in   (cadj[j]),
			.last_in  (clast[j]),
			.out_valid(cv[j+1]),
			.out_ready(cr[j+1]),
			.rem_out  (crem[j+1]),
			.len_out  (clen[j+1]),
			.q_out    (cq[j+1]),
			.neg_out  (cneg[j+1]),
			.adj_out  (cadj[j+1]),
			.last_out (clast[j+1])
		);
	end

	// sign and saturate the count
	for (genvar a = 0; a < NUM_AXES; a++) begin : g_sat
		always_comb begin
			if (cq[IW][a][IW-1]) begin
				img_next[a] = cneg[IW][a] ? IMIN : IMAX;
			end else begin
				img_next[a] = cneg[IW][a] ? IW'(-cq[IW][a]) : cq[IW][a];
			end
		end
	end

	// output register
	assign cr[IW] = !out_valid_q || img.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cr[IW]) begin
			out_valid_q <= cv[IW];
		end
	end

	always_ff @(posedge clk) begin
		if (cr[IW]) begin
			adj_q  <= cadj[IW];
			img_q  <= img_next;
			last_q <= clast[IW];
		end
	end

	assign img.valid    = out_valid_q;
	assign img.adj_x    = adj_q[0];
	assign img.adj_y    = adj_q[1];
	assign img.adj_z    = adj_q[2];
	assign img.image_x  = img_q[0];
	assign img.image_y  = img_q[1];
	assign img.image_z  = img_q[2];
	assign img.last_out = last_q;

	// an accepted transaction always lands in the snap stage
	a_accept_lands: assert property (@(posedge clk) disable iff (!arst_n)
		pos.valid && pos.ready |=> front_s1_valid)
		else $error("accepted transaction lost at snap stage");

	// input only backs up while the snap stage holds data
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!pos.ready |-> front_s1_valid)
		else $error("input stalled with empty snap stage");

	// last divider cell keeps its result while the output register is full
	a_chain_hold: assert property (@(posedge clk) disable iff (!arst_n)
		cv[IW] && !cr[IW] |=> cv[IW])
		else $error("divider result dropped under back-pressure");

endmodule

`default_nettype wire

[hdl/pii_front.sv]
`default_nettype none

// Front end: edge snap (s1), then bound compare and dividend setup (s2).
module pii_front #(
	parameter int COORD_WIDTH = pii_pkg::COORD_WIDTH_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// upstream
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic signed [COORD_WIDTH-1:0] pos_in    [pii_pkg::NUM_AXES],
	input  wire logic                          last_in,
	// box and tolerance
	input  wire logic signed [COORD_WIDTH-1:0] low       [pii_pkg::NUM_AXES],
	input  wire logic signed [COORD_WIDTH-1:0] high      [pii_pkg::NUM_AXES],
	input  wire logic [pii_pkg::TOL_WIDTH-1:0] tol,
	// downstream, into the divider chain
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic [COORD_WIDTH-1:0]             rem_out   [pii_pkg::NUM_AXES],
	output logic [COORD_WIDTH-1:0]             len_out   [pii_pkg::NUM_AXES],
	output logic                               neg_out   [pii_pkg::NUM_AXES],
	output logic signed [COORD_WIDTH-1:0]      adj_out   [pii_pkg::NUM_AXES],
	output logic                               last_out,
	// stage 1 occupancy
	output logic                               s1_valid
);
	import pii_pkg::*;

	localparam int CW = COORD_WIDTH;

	localparam logic [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};
	localparam logic [CW-1:0] CMIN = {1'b1, {(CW-1){1'b0}}};

	logic                 valid_s1;
	logic                 valid_s2;
	logic                 ready_s1;
	logic                 ready_s2;
	logic signed [CW-1:0] t_next   [NUM_AXES];
	logic signed [CW-1:0] t_s1     [NUM_AXES];
	logic                 last_s1;
	logic [CW-1:0]        rem_next [NUM_AXES];
	logic [CW-1:0]        len_next [NUM_AXES];
	logic                 neg_next [NUM_AXES];
	logic [CW-1:0]        rem_s2   [NUM_AXES];
	logic [CW-1:0]        len_s2   [NUM_AXES];
	logic                 neg_s2   [NUM_AXES];
	logic signed [CW-1:0] adj_s2   [NUM_AXES];
	logic                 last_s2;

	// stage handshake: a stage takes new data when empty or draining
	assign ready_s2 = !valid_s2 || out_ready;
	assign ready_s1 = !valid_s1 || ready_s2;
	assign in_ready = ready_s1;

	for (genvar a = 0; a < NUM_AXES; a++) begin : g_lane
		logic signed [CW:0] c_ext;
		logic signed [CW:0] tol_ext;
		logic signed [CW:0] d_lo;
		logic signed [CW:0] d_hi;
		logic [CW:0]        a_lo;
		logic [CW:0]        a_hi;
		logic               near_lo;
		logic               near_hi;
		logic signed [CW:0] sum_up;
		logic signed [CW:0] sum_dn;
		logic               ovf_up;
		logic               ovf_dn;
		logic               gt;
		logic               lt;
		logic               pos_len;

		// snap: distances to both faces, low face wins
		assign c_ext   = {pos_in[a][CW-1], pos_in[a]};
		assign tol_ext = {{(CW+1-TOL_WIDTH){1'b0}}, tol};
		assign d_lo    = c_ext - {low[a][CW-1], low[a]};
		assign d_hi    = c_ext - {high[a][CW-1], high[a]};
		assign a_lo    = d_lo[CW] ? (CW+1)'(-d_lo) : d_lo;
		assign a_hi    = d_hi[CW] ? (CW+1)'(-d_hi) : d_hi;
		assign near_lo = a_lo < tol_ext;
		assign near_hi = a_hi < tol_ext;
		assign sum_up  = c_ext + tol_ext;
		assign sum_dn  = c_ext - tol_ext;
		assign ovf_up  = sum_up[CW] != sum_up[CW-1];
		assign ovf_dn  = sum_dn[CW] != sum_dn[CW-1];

		always_comb begin
			if (near_lo) begin
				t_next[a] = ovf_up ? CMAX : sum_up[CW-1:0];
			end else if (near_hi) begin
				t_next[a] = ovf_dn ? CMIN : sum_dn[CW-1:0];
			end else begin
				t_next[a] = pos_in[a];
			end
		end

		// classify against the box and set up dividend and divisor
		assign gt      = t_s1[a] > high[a];
		assign lt      = t_s1[a] < low[a];
		assign pos_len = high[a] > low[a];

		always_comb begin
			rem_next[a] = '0;
			len_next[a] = CW'(1);
			neg_next[a] = 1'b0;
			if (pos_len && gt) begin
				rem_next[a] = t_s1[a] - low[a];
				len_next[a] = high[a] - low[a];
			end else if (pos_len && lt) begin
				rem_next[a] = high[a] - t_s1[a];
				len_next[a] = high[a] - low[a];
				neg_next[a] = 1'b1;
			end
		end
	end

	// stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (ready_s1) valid_s1 <= in_valid;
			if (ready_s2) valid_s2 <= valid_s1;
		end
	end

	// stage payloads
	always_ff @(posedge clk) begin
		if (ready_s1) begin
			t_s1    <= t_next;
			last_s1 <= last_in;
		end
		if (ready_s2) begin
			rem_s2  <= rem_next;
			len_s2  <= len_next;
			neg_s2  <= neg_next;
			adj_s2  <= t_s1;
			last_s2 <= last_s1;
		end
	end

	assign out_valid = valid_s2;
	assign rem_out   = rem_s2;
	assign len_out   = len_s2;
	assign neg_out   = neg_s2;
	assign adj_out   = adj_s2;
	assign last_out  = last_s2;
	assign s1_valid  = valid_s1;

endmodule

`default_nettype wire

[hdl/pii_div_cell.sv]
`default_nettype none

// One restoring-division cell: resolves the quotient bit of weight 2**SHIFT on
// every axis and hands the partial remainder to the next cell.
module pii_div_cell #(
	parameter int COORD_WIDTH = pii_pkg::COORD_WIDTH_DEF,
	parameter int IMAGE_WIDTH = pii_pkg::IMAGE_WIDTH_DEF,
	parameter int SHIFT       = 0
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic [COORD_WIDTH-1:0]        rem_in  [pii_pkg::NUM_AXES],
	input  wire logic [COORD_WIDTH-1:0]        len_in  [pii_pkg::NUM_AXES],
	input  wire logic [IMAGE_WIDTH-1:0]        q_in    [pii_pkg::NUM_AXES],
	input  wire logic                          neg_in  [pii_pkg::NUM_AXES],
	input  wire logic signed [COORD_WIDTH-1:0] adj_in  [pii_pkg::NUM_AXES],
	input  wire logic                          last_in,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic [COORD_WIDTH-1:0]             rem_out [pii_pkg::NUM_AXES],
	output logic [COORD_WIDTH-1:0]             len_out [pii_pkg::NUM_AXES],
	output logic [IMAGE_WIDTH-1:0]             q_out   [pii_pkg::NUM_AXES],
	output logic                               neg_out [pii_pkg::NUM_AXES],
	output logic signed [COORD_WIDTH-1:0]      adj_out [pii_pkg::NUM_AXES],
	output logic                               last_out
);
	import pii_pkg::*;

	localparam int CW = COORD_WIDTH;
	localparam int IW = IMAGE_WIDTH;
	localparam int RW = CW + IW - 1;

	logic                 valid_q;
	logic [CW-1:0]        rem_next [NUM_AXES];
	logic [IW-1:0]        q_next   [NUM_AXES];
	logic [CW-1:0]        rem_q    [NUM_AXES];
	logic [CW-1:0]        len_q    [NUM_AXES];
	logic [IW-1:0]        q_q      [NUM_AXES];
	logic                 neg_q    [NUM_AXES];
	logic signed [CW-1:0] adj_q    [NUM_AXES];
	logic                 last_q;

	assign in_ready = !valid_q || out_ready;

	// compare and subtract the shifted divisor
	for (genvar a = 0; a < NUM_AXES; a++) begin : g_lane
		logic [RW-1:0] dsh;
		logic [RW-1:0] rem_ext;
		logic [CW-1:0] diff;
		logic          take;

		assign dsh         = {{(IW-1){1'b0}}, len_in[a]} << SHIFT;
		assign rem_ext     = {{(IW-1){1'b0}}, rem_in[a]};
		// when the bit is taken the shifted divisor fits in the remainder width
		assign diff        = rem_in[a] - dsh[CW-1:0];
		assign take        = rem_ext >= dsh;
		assign rem_next[a] = take ? diff : rem_in[a];
		assign q_next[a]   = {q_in[a][IW-2:0], take};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready) begin
			rem_q  <= rem_next;
			len_q  <= len_in;
			q_q    <= q_next;
			neg_q  <= neg_in;
			adj_q  <= adj_in;
			last_q <= last_in;
		end
	end

	assign out_valid = valid_q;
	assign rem_out   = rem_q;
	assign len_out   = len_q;
	assign q_out     = q_q;
	assign neg_out   = neg_q;
	assign adj_out   = adj_q;
	assign last_out  = last_q;

endmodule

`default_nettype wire
